// ===== rtl/lscd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_pkg: shared definitions of the change dispenser
// Denomination tables, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package lscd_pkg;

  localparam int DENOM_COUNT = 7;
  localparam int SLOT_W      = (DENOM_COUNT > 1) ? $clog2(DENOM_COUNT) : 1;
  localparam int AMT_W       = 13;
  localparam int CNT_W       = 5;
  localparam int TILL_W      = 12;
  localparam int VAL_W       = 9;
  localparam int PAY_W       = CNT_W + VAL_W;
  // Reciprocal scale: AMT_W plus the bits of the largest value keeps the
  // multiply-and-shift quotient exact for every amount.
  localparam int RECIP_SHIFT = AMT_W + VAL_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = AMT_W + RECIP_W;

  // Value of one piece in half-units, largest first.
  function automatic logic [VAL_W-1:0] denom_value(input logic [SLOT_W-1:0] slot);
    logic [VAL_W-1:0] v;
    v = '0;
    case (int'(slot))
      0: v = VAL_W'(400);
      1: v = VAL_W'(200);
      2: v = VAL_W'(100);
      3: v = VAL_W'(20);
      4: v = VAL_W'(10);
      5: v = VAL_W'(2);
      6: v = VAL_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // ceil(2^RECIP_SHIFT / value); zero for an empty slot.
  function automatic logic [RECIP_W-1:0] denom_recip(input logic [SLOT_W-1:0] slot);
    logic [RECIP_W-1:0] r;
    r = '0;
    case (int'(slot))
      0: r = RECIP_W'(10486);
      1: r = RECIP_W'(20972);
      2: r = RECIP_W'(41944);
      3: r = RECIP_W'(209716);
      4: r = RECIP_W'(419431);
      5: r = RECIP_W'(2097152);
      6: r = RECIP_W'(4194304);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Pieces on hand after reset.
  function automatic logic [CNT_W-1:0] denom_reset(input logic [SLOT_W-1:0] slot);
    logic [CNT_W-1:0] c;
    c = '0;
    case (int'(slot))
      0: c = CNT_W'(2);
      1: c = CNT_W'(4);
      2: c = CNT_W'(6);
      3: c = CNT_W'(10);
      4: c = CNT_W'(10);
      5: c = CNT_W'(20);
      6: c = CNT_W'(20);
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic int till_reset_sum();
    int sum;
    sum = 0;
    for (int i = 0; i < DENOM_COUNT; i++) begin
      sum += int'(denom_value(SLOT_W'(i))) * int'(denom_reset(SLOT_W'(i)));
    end
    return sum;
  endfunction

  localparam int TILL_RESET = till_reset_sum();

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture the amount, restart at slot 0
    logic div;      // register the quotient of the remainder
    logic sub;      // take pieces, lower the remainder, next slot
    logic commit;   // settle stock or roll back
    logic advance;  // record beat taken, next slot
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic slot_last;
  } dp_stat_t;

endpackage

// ===== rtl/lscd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_ctrl: sequencer of the change dispenser
// Steps the datapath through divide, take, commit and record phases.
// ----------------------------------------------------------------------------
module lscd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lscd_pkg::dp_stat_t stat_i,
  output lscd_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_SUB    = 3'd2;
  localparam logic [2:0] ST_COMMIT = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = stat_i.slot_last ? ST_COMMIT : ST_DIV;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.advance = 1'b1;
          if (stat_i.slot_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while records pending");

  a_commit_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("no record after commit");

endmodule

// ===== rtl/lscd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscd_datapath: stock, remainder and record registers
// Reciprocal divide, capped take, stock commit and record selection.
// ----------------------------------------------------------------------------
module lscd_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lscd_pkg::dp_cmd_t                   cmd_i,
  output lscd_pkg::dp_stat_t                  stat_o,
  input  logic [lscd_pkg::AMT_W-1:0]          change_amount_i,
  output logic [lscd_pkg::SLOT_W-1:0]         slot_o,
  output logic [lscd_pkg::CNT_W-1:0]          piece_count_o,
  output logic                                short_o,
  output logic [lscd_pkg::TILL_W-1:0]         till_o
);

  logic [lscd_pkg::AMT_W-1:0]  amount_q;
  logic [lscd_pkg::AMT_W-1:0]  rem_q, rem_d;
  logic [lscd_pkg::CNT_W-1:0]  quot_q, quot_d;
  logic [lscd_pkg::SLOT_W-1:0] slot_q;
  logic [lscd_pkg::CNT_W-1:0]  paid_q  [lscd_pkg::DENOM_COUNT];
  logic [lscd_pkg::CNT_W-1:0]  stock_q [lscd_pkg::DENOM_COUNT];
  logic                        short_q;
  logic [lscd_pkg::TILL_W-1:0] till_q;

  logic                        slot_last;
  logic [lscd_pkg::PROD_W-1:0] prod;
  logic [lscd_pkg::AMT_W-1:0]  quot_full;
  logic [lscd_pkg::CNT_W-1:0]  take;
  logic [lscd_pkg::PAY_W-1:0]  pay;

  assign slot_last = (slot_q == lscd_pkg::SLOT_W'(lscd_pkg::DENOM_COUNT - 1));
  assign stat_o.slot_last = slot_last;

  // Remainder divided by the slot value through its scaled reciprocal.
  assign prod = lscd_pkg::PROD_W'(rem_q)
              * lscd_pkg::PROD_W'(lscd_pkg::denom_recip(slot_q));
  assign quot_full = prod[lscd_pkg::RECIP_SHIFT +: lscd_pkg::AMT_W];

  always_comb begin
    if (quot_full > lscd_pkg::AMT_W'({lscd_pkg::CNT_W{1'b1}})) begin
      quot_d = '1;
    end else begin
      quot_d = quot_full[lscd_pkg::CNT_W-1:0];
    end
  end

  // Cap the quotient at the stock on hand.
  assign take = (quot_q < stock_q[slot_q]) ? quot_q : stock_q[slot_q];
  assign pay  = lscd_pkg::PAY_W'(take) * lscd_pkg::PAY_W'(lscd_pkg::denom_value(slot_q));
  assign rem_d = rem_q - pay[lscd_pkg::AMT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      amount_q <= change_amount_i;
      rem_q    <= change_amount_i;
    end else if (cmd_i.sub) begin
      rem_q <= rem_d;
    end
    if (cmd_i.div) begin
      quot_q <= quot_d;
    end
    if (cmd_i.sub) begin
      paid_q[slot_q] <= take;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      short_q <= 1'b0;
      till_q  <= lscd_pkg::TILL_W'(lscd_pkg::TILL_RESET);
      for (int i = 0; i < lscd_pkg::DENOM_COUNT; i++) begin
        stock_q[i] <= lscd_pkg::denom_reset(lscd_pkg::SLOT_W'(i));
      end
    end else begin
      if (cmd_i.load) begin
        slot_q <= '0;
      end else if (cmd_i.sub || cmd_i.advance) begin
        slot_q <= slot_last ? '0 : slot_q + 1'b1;
      end
      if (cmd_i.commit) begin
        short_q <= (rem_q != '0);
        // Settle stock only when the whole amount was paid.
        if (rem_q == '0) begin
          till_q <= till_q - amount_q[lscd_pkg::TILL_W-1:0];
          for (int i = 0; i < lscd_pkg::DENOM_COUNT; i++) begin
            stock_q[i] <= stock_q[i] - paid_q[i];
          end
        end
      end
    end
  end

  assign slot_o        = slot_q;
  assign piece_count_o = short_q ? '0 : paid_q[slot_q];
  assign short_o       = short_q;
  assign till_o        = till_q;

  a_rem_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sub |=> rem_q <= $past(rem_q))
    else $error("remainder grew");

  a_till_paid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && rem_q == '0) |=>
      till_q == $past(till_q - amount_q[lscd_pkg::TILL_W-1:0]))
    else $error("till does not match amount paid");

  a_short_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && rem_q != '0) |=> $stable(till_q))
    else $error("till changed on short request");

endmodule

// ===== rtl/limited_stock_change_dispenser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limited_stock_change_dispenser: greedy change payout from a limited stock
// Pays a change amount from seven denominations and tracks stock and till.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) moves one beat: change_amount_i
//   in half-units. Output channel (out_valid_o / out_ready_i) returns seven
//   beats per request, one per denomination slot, largest first, with
//   last_record_o high on the seventh.
//   For each slot a divide step registers remainder / value through a
//   reciprocal multiply, and a take step caps it at the stock and lowers the
//   remainder. After the seven slots a commit step settles the stock, or
//   rolls it back and flags the request short. out_valid_o rises after the
//   commit step. A new amount is taken in the cycle after the seventh
//   record is accepted.
//   Reset restores the stock to 2, 4, 6, 10, 10, 20, 20 pieces and the till
//   to 2560 half-units; no clearing pass is needed.
//   When the receiver stalls, the current record holds on the outputs and
//   in_ready_o stays low until all records are gone.
// ----------------------------------------------------------------------------
module limited_stock_change_dispenser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lscd_pkg::AMT_W-1:0]  change_amount_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  denom_index_o,
  output logic [lscd_pkg::CNT_W-1:0]  piece_count_o,
  output logic                        short_flag_o,
  output logic [lscd_pkg::TILL_W-1:0] till_value_o,
  output logic                        last_record_o
);

  lscd_pkg::dp_cmd_t           cmd;
  lscd_pkg::dp_stat_t          stat;
  logic [lscd_pkg::SLOT_W-1:0] slot;

  // Sequence the phases of one request.
  lscd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the stock, the till and the records of the current request.
  lscd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .change_amount_i (change_amount_i),
    .slot_o          (slot),
    .piece_count_o   (piece_count_o),
    .short_o         (short_flag_o),
    .till_o          (till_value_o)
  );

  // Slot number fits the 3-bit record field.
  assign denom_index_o = 3'(slot);
  assign last_record_o = stat.slot_last;

endmodule
